>>> src/cluster_sse_cost_assert.svh
// assertion helpers for the sse cost block
`ifndef CLUSTER_SSE_COST_ASSERT_SVH
`define CLUSTER_SSE_COST_ASSERT_SVH

// same-cycle implication, held off during reset
`define CSSC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define CSSC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cssc_pkg.sv
package cssc_pkg;

    localparam int LABEL_W    = 4;
    localparam int DIM_REG_W  = 4;
    localparam int CLUS_REG_W = 5;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int SSE_W      = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMENSION = 1'b0,
        CFG_CLUSTERS  = 1'b1
    } cfg_idx_t;

endpackage

>>> src/cssc_ram.sv
module cssc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/cssc_div.sv
module cssc_div #(
    parameter int NW  = 27,
    parameter int DVW = 11
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [NW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [NW-1:0]  quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [DVW-1:0]   rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVW:0]     shifted;
    logic             ge;
    logic [DVW:0]     rem_next;

    // one quotient bit a cycle, restoring
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NW-1]};
        ge       = shifted >= {1'b0, divisor};
        rem_next = ge ? (shifted - {1'b0, divisor}) : shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            // last quotient bit lands on the count-of-one step
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(NW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next[DVW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/cluster_sse_cost.sv
// k-means sum-of-squared-errors cost. a data set arrives one coordinate per
// request (point by point, dimension by dimension), each carrying its
// point's label, the final one marked by last_of_set. while loading, a
// request is taken in ST_IDLE and done in ST_LOAD: the per-cluster
// coordinate sum is read from and written back to its ram. after the final
// request the block stays busy: the centroid pass visits every (cluster,
// dimension) in use, running the shared bit-serial divider when the cluster
// has members; the error pass then rereads every stored coordinate through
// the label, centroid and squarer path, and ST_EMIT forms the result. the
// total is emitted once on sse/saturated/bad_input with done high for
// exactly one cycle; the receiver cannot stall it. when bad_input is 1, sse
// and saturated are 0. the user must write configuration only while busy
// is low and no set is open; the block itself does not enforce it.
`include "cluster_sse_cost_assert.svh"

module cluster_sse_cost #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_DIM      = 8,
    parameter int MAX_CLUSTERS = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [COORD_WIDTH-1:0]           coord,
    input  logic [cssc_pkg::LABEL_W-1:0]     point_cluster,
    input  logic                             last_of_set,
    input  logic                             cfg_write,
    input  logic [cssc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cssc_pkg::CFG_W-1:0]       cfg_data,
    output logic                             done,
    output logic [cssc_pkg::SSE_W-1:0]      sse,
    output logic                             saturated,
    output logic                             bad_input
);

    import cssc_pkg::*;

    localparam int CW        = COORD_WIDTH;
    localparam int ST_DEPTH  = MAX_POINTS * MAX_DIM;
    localparam int ST_AW     = $clog2(ST_DEPTH);
    localparam int LB_AW     = $clog2(MAX_POINTS);
    localparam int PT_W      = $clog2(MAX_POINTS + 1);
    localparam int SUM_DEPTH = MAX_CLUSTERS * MAX_DIM;
    localparam int SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
    localparam int SUM_W     = CW + $clog2(MAX_POINTS) + 1;
    localparam int MEM_W     = $clog2(MAX_POINTS + 1);
    localparam int POS_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW        = $clog2(MAX_DIM + 1);
    localparam int CL_W      = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int KW        = $clog2(MAX_CLUSTERS + 1);
    localparam int PW        = 2 * (CW + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CEN_RD,
        ST_CEN_CHK,
        ST_CEN_DIV,
        ST_SSE_RD,
        ST_SSE_CEN,
        ST_SSE_MUL,
        ST_SSE_ACC,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [DIM_REG_W-1:0]  dim_reg;
    logic [CLUS_REG_W-1:0] clus_reg;
    logic [DW-1:0]         d_eff;
    logic [KW-1:0]         k_eff;

    // set state
    logic [ST_AW-1:0]      elem_reg;
    logic [PT_W-1:0]       pt_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [LABEL_W-1:0]    cur_lab_reg;
    logic                  cur_ok_reg;
    logic                  err_reg;
    logic [MEM_W-1:0]      members_reg [MAX_CLUSTERS];
    logic [SUM_DEPTH-1:0]  sv_reg;
    logic [SSE_W-1:0]      total_reg;
    logic                  sat_reg;

    // per-request holding
    logic signed [CW-1:0]  coord_reg;
    logic                  add_ok_reg;
    logic                  last_reg;
    logic [SUM_AW-1:0]     sum_addr_reg;

    // pass counters
    logic [CL_W-1:0]       c_reg;
    logic [POS_W-1:0]      j_reg;
    logic [PT_W-1:0]       p_reg;
    logic [ST_AW-1:0]      addr_reg;
    logic                  sign_reg;
    logic signed [CW-1:0]  pd_reg;
    logic [PW-1:0]         sq_reg;

    // result
    logic                  done_reg;
    logic [SSE_W-1:0]      sse_reg;
    logic                  sat_out_reg;
    logic                  bad_reg;

    // request decode
    logic                  accept;
    logic                  stored;
    logic                  first;
    logic                  lab_ok;
    logic [LABEL_W-1:0]    add_lab;
    logic                  add_ok;
    logic [SUM_AW-1:0]     load_addr;
    logic [SUM_AW-1:0]     cen_addr;
    logic [CL_W-1:0]       mem_idx;
    logic [MEM_W-1:0]      mem_val;
    logic                  pos_wrap;
    logic                  j_wrap;
    logic                  c_last;

    // memories
    logic [CW-1:0]         pt_rdata;
    logic [LABEL_W-1:0]    lab_rdata;
    logic                  sum_we;
    logic [SUM_AW-1:0]     sum_raddr;
    logic [SUM_W-1:0]      sum_rdata;
    logic signed [SUM_W-1:0] sum_val;
    logic signed [SUM_W-1:0] sum_wdata;
    logic                  cen_we;
    logic [CW-1:0]         cen_wdata;
    logic [SUM_AW-1:0]     cen_raddr;
    logic [CW-1:0]         cen_rdata;

    // divider
    logic                  div_start;
    logic [SUM_W-1:0]      div_num;
    logic                  div_done;
    logic [SUM_W-1:0]      div_q;
    logic [SUM_W-1:0]      q_signed;

    // error path
    logic signed [CW:0]    diff;
    logic [CW:0]           mag;
    logic                  sq_ovf;
    logic [SSE_W-1:0]      sq_lo;
    logic [SSE_W:0]        acc_sum;

    // registers out of range act as the nearest legal value
    always_comb
    begin
        if (dim_reg == '0)
            d_eff = DW'(1);
        else if (int'(dim_reg) > MAX_DIM)
            d_eff = DW'(MAX_DIM);
        else
            d_eff = DW'(dim_reg);

        if (clus_reg == '0)
            k_eff = KW'(1);
        else if (int'(clus_reg) > MAX_CLUSTERS)
            k_eff = KW'(MAX_CLUSTERS);
        else
            k_eff = KW'(clus_reg);
    end

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign stored = (int'(pt_reg) < MAX_POINTS);
    assign first  = (pos_reg == '0);
    assign lab_ok = (int'(point_cluster) < int'(k_eff));

    // the label comes from a point's first coordinate; later ones reuse it
    assign add_lab   = first ? point_cluster : cur_lab_reg;
    assign add_ok    = stored && (first ? lab_ok : cur_ok_reg);
    assign load_addr = SUM_AW'(int'(add_lab) * MAX_DIM + int'(pos_reg));
    assign cen_addr  = SUM_AW'(int'(c_reg) * MAX_DIM + int'(j_reg));

    assign mem_idx = (state_reg == ST_IDLE) ? CL_W'(point_cluster) : c_reg;
    assign mem_val = members_reg[mem_idx];

    assign pos_wrap = (int'(pos_reg) + 1 == int'(d_eff));
    assign j_wrap   = (int'(j_reg) + 1 == int'(d_eff));
    assign c_last   = (int'(c_reg) + 1 == int'(k_eff));

    // sum read-modify-write; an entry not yet touched this set reads as zero
    assign sum_raddr = (state_reg == ST_IDLE) ? load_addr : cen_addr;
    assign sum_val   = sv_reg[sum_addr_reg] ? signed'(sum_rdata) : '0;
    assign sum_wdata = sum_val + SUM_W'(coord_reg);
    assign sum_we    = (state_reg == ST_LOAD) && add_ok_reg;

    // centroid = sum / members, truncated toward zero
    assign div_start = (state_reg == ST_CEN_CHK) && (mem_val != '0);
    assign div_num   = sum_val[SUM_W-1] ? SUM_W'(-sum_val) : SUM_W'(sum_val);
    assign q_signed  = sign_reg ? (~div_q + 1'b1) : div_q;
    assign cen_we    = ((state_reg == ST_CEN_CHK) && (mem_val == '0))
                     || ((state_reg == ST_CEN_DIV) && div_done);
    assign cen_wdata = (state_reg == ST_CEN_CHK) ? '0 : q_signed[CW-1:0];
    assign cen_raddr = SUM_AW'(int'(lab_rdata) * MAX_DIM + int'(j_reg));

    // squared distance of one coordinate
    assign diff = (CW+1)'(pd_reg) - (CW+1)'(signed'(cen_rdata));
    assign mag  = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);

    generate
        if (PW > SSE_W)
        begin : g_wide_sq
            assign sq_ovf = |sq_reg[PW-1:SSE_W];
            assign sq_lo  = sq_reg[SSE_W-1:0];
        end
        else
        begin : g_narrow_sq
            assign sq_ovf = 1'b0;
            assign sq_lo  = SSE_W'(sq_reg);
        end
    endgenerate

    assign acc_sum = {1'b0, total_reg} + {1'b0, sq_lo};

    cssc_ram #(
        .WIDTH (CW),
        .DEPTH (ST_DEPTH)
    ) u_point_ram (
        .clk   (clk),
        .we    (accept && stored),
        .waddr (elem_reg),
        .wdata (coord),
        .raddr (addr_reg),
        .rdata (pt_rdata)
    );

    cssc_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (MAX_POINTS)
    ) u_label_ram (
        .clk   (clk),
        .we    (accept && stored && first && lab_ok),
        .waddr (pt_reg[LB_AW-1:0]),
        .wdata (point_cluster),
        .raddr (p_reg[LB_AW-1:0]),
        .rdata (lab_rdata)
    );

    cssc_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SUM_DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_addr_reg),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    cssc_ram #(
        .WIDTH (CW),
        .DEPTH (SUM_DEPTH)
    ) u_cen_ram (
        .clk   (clk),
        .we    (cen_we),
        .waddr (cen_addr),
        .wdata (cen_wdata),
        .raddr (cen_raddr),
        .rdata (cen_rdata)
    );

    cssc_div #(
        .NW  (SUM_W),
        .DVW (MEM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (mem_val),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer, set state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dim_reg     <= DIM_REG_W'(2);
            clus_reg    <= CLUS_REG_W'(2);
            elem_reg    <= '0;
            pt_reg      <= '0;
            pos_reg     <= '0;
            cur_lab_reg <= '0;
            cur_ok_reg  <= 1'b0;
            err_reg     <= 1'b0;
            sv_reg      <= '0;
            total_reg   <= '0;
            sat_reg     <= 1'b0;
            add_ok_reg  <= 1'b0;
            last_reg    <= 1'b0;
            c_reg       <= '0;
            j_reg       <= '0;
            p_reg       <= '0;
            addr_reg    <= '0;
            done_reg    <= 1'b0;
            sse_reg     <= '0;
            sat_out_reg <= 1'b0;
            bad_reg     <= 1'b0;
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                members_reg[i] <= '0;
            end
        end
        else
        begin
            // result strobe follows the emit cycle
            done_reg <= (state_reg == ST_EMIT);

            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_DIMENSION: dim_reg  <= cfg_data[DIM_REG_W-1:0];
                    CFG_CLUSTERS:  clus_reg <= cfg_data[CLUS_REG_W-1:0];
                    default:       ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        add_ok_reg <= add_ok;
                        last_reg   <= last_of_set;
                        if (!stored)
                        begin
                            err_reg <= 1'b1;
                        end
                        else
                        begin
                            if (first)
                            begin
                                cur_lab_reg <= point_cluster;
                                cur_ok_reg  <= lab_ok;
                                if (lab_ok)
                                    members_reg[mem_idx] <= mem_val + 1'b1;
                                else
                                    err_reg <= 1'b1;
                            end
                            elem_reg <= elem_reg + 1'b1;
                            if (pos_wrap)
                            begin
                                pos_reg <= '0;
                                pt_reg  <= pt_reg + 1'b1;
                            end
                            else
                            begin
                                pos_reg <= pos_reg + 1'b1;
                            end
                        end
                        state_reg <= ST_LOAD;
                    end
                end

                ST_LOAD:
                begin
                    if (add_ok_reg)
                        sv_reg[sum_addr_reg] <= 1'b1;
                    if (last_reg)
                    begin
                        // set ended inside a point
                        if (pos_reg != '0)
                            err_reg <= 1'b1;
                        c_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_CEN_RD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_CEN_RD:
                begin
                    state_reg <= ST_CEN_CHK;
                end

                ST_CEN_CHK, ST_CEN_DIV:
                begin
                    if (state_reg == ST_CEN_CHK && mem_val != '0)
                    begin
                        state_reg <= ST_CEN_DIV;
                    end
                    else if (state_reg == ST_CEN_CHK || div_done)
                    begin
                        if (j_wrap)
                        begin
                            j_reg <= '0;
                            if (c_last)
                            begin
                                p_reg     <= '0;
                                addr_reg  <= '0;
                                state_reg <= (pt_reg == '0) ? ST_EMIT : ST_SSE_RD;
                            end
                            else
                            begin
                                c_reg     <= c_reg + 1'b1;
                                state_reg <= ST_CEN_RD;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_CEN_RD;
                        end
                    end
                end

                ST_SSE_RD:  state_reg <= ST_SSE_CEN;
                ST_SSE_CEN: state_reg <= ST_SSE_MUL;
                ST_SSE_MUL: state_reg <= ST_SSE_ACC;

                ST_SSE_ACC:
                begin
                    if (sq_ovf || acc_sum[SSE_W])
                    begin
                        total_reg <= '1;
                        sat_reg   <= 1'b1;
                    end
                    else
                    begin
                        total_reg <= acc_sum[SSE_W-1:0];
                    end
                    addr_reg <= addr_reg + 1'b1;
                    if (j_wrap)
                    begin
                        j_reg     <= '0;
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= (p_reg + 1'b1 == pt_reg) ? ST_EMIT : ST_SSE_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_SSE_RD;
                    end
                end

                ST_EMIT:
                begin
                    bad_reg     <= err_reg;
                    sse_reg     <= err_reg ? '0 : total_reg;
                    sat_out_reg <= !err_reg && (sat_reg || (total_reg == '1));
                    // clear the set for the next one
                    elem_reg    <= '0;
                    pt_reg      <= '0;
                    pos_reg     <= '0;
                    err_reg     <= 1'b0;
                    sv_reg      <= '0;
                    total_reg   <= '0;
                    sat_reg     <= 1'b0;
                    for (int i = 0; i < MAX_CLUSTERS; i++)
                    begin
                        members_reg[i] <= '0;
                    end
                    state_reg   <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // request and datapath holding registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_reg    <= signed'(coord);
            sum_addr_reg <= load_addr;
        end
        else if (state_reg == ST_CEN_RD)
        begin
            sum_addr_reg <= cen_addr;
        end

        if (state_reg == ST_CEN_CHK)
            sign_reg <= sum_val[SUM_W-1];
        if (state_reg == ST_SSE_CEN)
            pd_reg <= signed'(pt_rdata);
        if (state_reg == ST_SSE_MUL)
            sq_reg <= {{(CW+1){1'b0}}, mag} * {{(CW+1){1'b0}}, mag};
    end

    assign done      = done_reg;
    assign sse       = sse_reg;
    assign saturated = sat_out_reg;
    assign bad_input = bad_reg;

    // a flagged set reports neither a total nor saturation
    `CSSC_ASSERT_NOW(a_bad_clears_total, clk, rst_n, done && bad_input,
        (sse == '0) && !saturated, "bad set reported a total")

    // one result per set; the result strobe is never held high
    `CSSC_ASSERT_NEXT(a_single_result, clk, rst_n, done, !done,
        "result strobe held for two cycles")

    // an accepted request always occupies the block for its update
    `CSSC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy,
        "request accepted without going busy")

    // divider only runs inside the centroid pass
    `CSSC_ASSERT_NOW(a_div_in_pass, clk, rst_n, div_done,
        state_reg == ST_CEN_DIV, "divider finished outside the centroid pass")

endmodule
